// ----- rtl/lkv_pkg.sv -----
// Shared constants, codes and bus types for the linear key-value table.
// Used by lkv_cell and linear_key_value_table_top; no dependencies.
package lkv_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_APPEND = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // search token moving down the cell chain
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] rdata;
    } srch_t;

    // write bus broadcast to all cells
    typedef struct packed {
        logic              key_en;
        logic              value_en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } wr_t;

endpackage

// ----- rtl/lkv_cell.sv -----
// One table entry: key/value storage plus one stage of the search chain.
// Depends on lkv_pkg.
module lkv_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lkv_pkg::IDX_W-1:0]  cell_idx,
    input  logic [lkv_pkg::DATA_W-1:0] search_key,
    input  logic [lkv_pkg::CNT_W-1:0]  count,
    input  lkv_pkg::wr_t               wr,
    input  lkv_pkg::srch_t             tok_in,
    output lkv_pkg::srch_t             tok_out
);

    logic [lkv_pkg::DATA_W-1:0] key_reg;
    logic [lkv_pkg::DATA_W-1:0] value_reg;
    lkv_pkg::srch_t             tok_reg;
    lkv_pkg::srch_t             tok_next;
    logic                       in_use;
    logic                       hit;

    assign in_use = {{(lkv_pkg::CNT_W - lkv_pkg::IDX_W){1'b0}}, cell_idx} < count;
    assign hit    = tok_in.valid & ~tok_in.found & in_use & (key_reg == search_key);

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found | hit;
        if (hit)
        begin
            tok_next.idx   = cell_idx;
            tok_next.rdata = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.key_en && (wr.idx == cell_idx))
        begin
            key_reg <= wr.key;
        end
        if (wr.value_en && (wr.idx == cell_idx))
        begin
            value_reg <= wr.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- rtl/linear_key_value_table_top.sv -----
// Linear key-value table top: command control, result registers, cell chain.
// Depends on lkv_pkg and lkv_cell.
//
//  channel   handshake          payload
//  command   start, busy        operation, key, value
//  result    done (strobe)      status, read_value, hit_index, entry_count
//
// Pop and append: result in the cycle after the transaction, busy stays low.
// Set and lookup: a search token walks the CAPACITY-cell chain one cell per
// cycle, from the launch register through each cell register; the result is
// registered once the token leaves the chain, busy high meanwhile.
// Reset clears the fill count and control state; stored entries are not cleared.
// Results are strobed for one cycle; the receiver cannot stall.
module linear_key_value_table_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        operation,
    input  logic signed [lkv_pkg::DATA_W-1:0] key,
    input  logic signed [lkv_pkg::DATA_W-1:0] value,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [lkv_pkg::DATA_W-1:0] read_value,
    output logic [lkv_pkg::IDX_W-1:0]         hit_index,
    output logic [lkv_pkg::CNT_W-1:0]         entry_count
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_SEARCH = 1'b1;

    logic                       state_reg, state_next;
    logic                       launch_reg, launch_next;
    logic [1:0]                 op_reg;
    logic [lkv_pkg::DATA_W-1:0] key_reg;
    logic [lkv_pkg::DATA_W-1:0] value_reg;
    logic [lkv_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       done_reg, done_next;
    logic [1:0]                 status_reg, status_next;
    logic [lkv_pkg::DATA_W-1:0] rdata_reg, rdata_next;
    logic [lkv_pkg::IDX_W-1:0]  idx_reg, idx_next;

    logic                       accept;
    logic                       full;
    lkv_pkg::wr_t               wr;
    lkv_pkg::srch_t             chain [lkv_pkg::CAPACITY+1];
    lkv_pkg::srch_t             tail;

    assign accept = start && !busy;
    assign full   = count_reg == lkv_pkg::CNT_W'(lkv_pkg::CAPACITY);
    assign tail   = chain[lkv_pkg::CAPACITY];

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = launch_reg;
    end

    for (genvar g = 0; g < lkv_pkg::CAPACITY; g++)
    begin : g_cell
        lkv_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (lkv_pkg::IDX_W'(g)),
            .search_key (key_reg),
            .count      (count_reg),
            .wr         (wr),
            .tok_in     (chain[g]),
            .tok_out    (chain[g+1])
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        count_next  = count_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rdata_next  = rdata_reg;
        idx_next    = idx_reg;
        wr          = '0;

        if (accept)
        begin
            unique case (operation) inside
                lkv_pkg::OP_POP:
                begin
                    done_next  = 1'b1;
                    rdata_next = '0;
                    idx_next   = '0;
                    if (count_reg == '0)
                    begin
                        status_next = lkv_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        status_next = lkv_pkg::ST_OK;
                        count_next  = count_reg - lkv_pkg::CNT_W'(1);
                    end
                end
                lkv_pkg::OP_APPEND:
                begin
                    done_next  = 1'b1;
                    rdata_next = '0;
                    if (full)
                    begin
                        status_next = lkv_pkg::ST_FULL;
                        idx_next    = '0;
                    end
                    else
                    begin
                        status_next = lkv_pkg::ST_OK;
                        idx_next    = count_reg[lkv_pkg::IDX_W-1:0];
                        count_next  = count_reg + lkv_pkg::CNT_W'(1);
                        wr.key_en   = 1'b1;
                        wr.value_en = 1'b1;
                        wr.idx      = count_reg[lkv_pkg::IDX_W-1:0];
                        wr.key      = key;
                        wr.value    = value;
                    end
                end
                lkv_pkg::OP_SET, lkv_pkg::OP_LOOKUP:
                begin
                    state_next  = S_SEARCH;
                    launch_next = 1'b1;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end

        if ((state_reg == S_SEARCH) && tail.valid)
        begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            rdata_next = '0;
            idx_next   = '0;
            if (op_reg == lkv_pkg::OP_LOOKUP)
            begin
                if (tail.found)
                begin
                    status_next = lkv_pkg::ST_OK;
                    rdata_next  = tail.rdata;
                    idx_next    = tail.idx;
                end
                else
                begin
                    status_next = lkv_pkg::ST_MISS;
                end
            end
            else if (tail.found)
            begin
                status_next = lkv_pkg::ST_OK;
                idx_next    = tail.idx;
                wr.value_en = 1'b1;
                wr.idx      = tail.idx;
                wr.value    = value_reg;
            end
            else if (full)
            begin
                status_next = lkv_pkg::ST_FULL;
            end
            else
            begin
                status_next = lkv_pkg::ST_OK;
                idx_next    = count_reg[lkv_pkg::IDX_W-1:0];
                count_next  = count_reg + lkv_pkg::CNT_W'(1);
                wr.key_en   = 1'b1;
                wr.value_en = 1'b1;
                wr.idx      = count_reg[lkv_pkg::IDX_W-1:0];
                wr.key      = key_reg;
                wr.value    = value_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            launch_reg <= 1'b0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            value_reg <= value;
        end
        status_reg <= status_next;
        rdata_reg  <= rdata_next;
        idx_reg    <= idx_next;
    end

    assign busy        = state_reg == S_SEARCH;
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = rdata_reg;
    assign hit_index   = idx_reg;
    assign entry_count = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= lkv_pkg::CNT_W'(lkv_pkg::CAPACITY))
        else $error("fill count above capacity");

    a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> (state_reg == S_SEARCH))
        else $error("search token left chain outside search");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (done_reg || (state_reg == S_SEARCH)))
        else $error("transaction neither answered nor searching");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == lkv_pkg::ST_FULL))
            |-> (count_reg == lkv_pkg::CNT_W'(lkv_pkg::CAPACITY)))
        else $error("full reported below capacity");

endmodule
